### rtl/sbh_pkg.sv
`timescale 1ns / 1ps

package sbh_pkg;

    // Stream payload widths; the data widths are padded to whole bytes.
    localparam int S_DATA_W = 96;  // point_x, point_y, point_z
    localparam int S_USER_W = 2;   // kind, point_invalid
    localparam int M_DATA_W = 80;  // normal_x, normal_y, normal_z, plane_offset
    localparam int M_USER_W = 3;   // plane_index

    localparam int MARGIN_W = 31;
    localparam logic [MARGIN_W-1:0] MARGIN_RESET = 31'd32768;

    // Item kinds.
    localparam logic KIND_START    = 1'b0;
    localparam logic KIND_WAYPOINT = 1'b1;

    // Plane codes carried on the result tuser.
    localparam logic [M_USER_W-1:0] PLANE_AX_POS = 3'd0;
    localparam logic [M_USER_W-1:0] PLANE_UP_NEG = 3'd5;

    // Unit length in Q1.14.
    localparam logic signed [15:0] Q14_ONE = 16'sd16384;

endpackage

### rtl/segment_box_halfspaces.sv
`timescale 1ns / 1ps

// Oriented box halfspaces along a route. Points arrive one beat at a time on the slave
// stream; a start point (or the first valid waypoint) only sets the previous point, and
// beats flagged invalid are dropped without any effect. Each later waypoint closes a segment
// and, unless the segment has zero length, produces six plane beats (+axial, -axial, +side,
// -side, +up, -up) on the master stream, each a Q1.14 unit normal and a saturated Q16.16
// offset such that n.p + offset <= 0 holds inside the box; the sixth beat carries tlast.
// The work of a segment is set by the one shared iterative unit: a bit-serial square root
// (four per segment, three for a vertical one), a restoring divider (nine normal components,
// each with its own setup, six for a vertical segment), one-bit normalization shifts for
// each unit vector, and one 34x34 multiplier used for squares, the cross product and the
// dot products. A full output register stalls the sequence. The block takes no new point
// until the sixth plane has been loaded into the output register. box_margin is to be
// written through cfg_wr_en and cfg_wr_data only while the block is idle; the block
// itself does not enforce this.
module segment_box_halfspaces (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [sbh_pkg::S_DATA_W-1:0]  s_tdata,   // point_x, point_y, point_z
    input  logic [sbh_pkg::S_USER_W-1:0]  s_tuser,   // kind, point_invalid
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [sbh_pkg::M_DATA_W-1:0]  m_tdata,   // normal_x, normal_y, normal_z,
                                                     // plane_offset
    output logic [sbh_pkg::M_USER_W-1:0]  m_tuser,   // plane_index
    output logic                          m_tlast,   // last_plane
    input  logic                          cfg_wr_en,
    input  logic [sbh_pkg::MARGIN_W-1:0]  cfg_wr_data
);
    import sbh_pkg::*;

    // Sequencer states.
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_CHK   = 4'd1;
    localparam logic [3:0] ST_HSQ   = 4'd2;
    localparam logic [3:0] ST_ROOT  = 4'd3;
    localparam logic [3:0] ST_USET  = 4'd4;
    localparam logic [3:0] ST_UNORM = 4'd5;
    localparam logic [3:0] ST_USQ   = 4'd6;
    localparam logic [3:0] ST_DINIT = 4'd7;
    localparam logic [3:0] ST_DIV   = 4'd8;
    localparam logic [3:0] ST_UDONE = 4'd9;
    localparam logic [3:0] ST_CROSS = 4'd10;
    localparam logic [3:0] ST_DOT   = 4'd11;
    localparam logic [3:0] ST_OFS   = 4'd12;
    localparam logic [3:0] ST_EMP   = 4'd13;
    localparam logic [3:0] ST_EMM   = 4'd14;

    // Which unit vector the shared unit is working on.
    localparam logic [1:0] U_AXIS = 2'd0;
    localparam logic [1:0] U_SIDE = 2'd1;
    localparam logic [1:0] U_UP   = 2'd2;

    function automatic logic [33:0] mag34(input logic signed [33:0] v);
        return v[33] ? 34'(-v) : 34'(v);
    endfunction

    function automatic logic [31:0] sat54(input logic signed [53:0] v);
        if (v > 54'sd2147483647) begin
            return 32'h7FFF_FFFF;
        end else if (v < -54'sd2147483648) begin
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    // Control state.
    logic [3:0]          state_reg;
    logic [4:0]          cnt_reg;
    logic [1:0]          comp_reg;
    logic [1:0]          k_reg;
    logic [1:0]          usel_reg;
    logic                root_half_reg;
    logic                have_prev_reg;
    logic signed [31:0]  prev_x_reg, prev_y_reg, prev_z_reg;
    logic [MARGIN_W-1:0] margin_reg;
    logic                m_valid_reg;

    // Datapath.
    logic signed [32:0]  d_reg  [3];
    logic signed [32:0]  cs_reg [3];
    logic [31:0]         half_reg;
    logic signed [67:0]  acc_reg;
    logic [63:0]         rad_reg;
    logic [31:0]         root_reg;
    logic [35:0]         rem_reg;
    logic [33:0]         a_reg [3];
    logic [2:0]          vneg_reg;
    logic [47:0]         drem_reg, dsh_reg;
    logic [15:0]         q_reg;
    logic signed [15:0]  ax_reg [3];
    logic signed [15:0]  sd_reg [3];
    logic signed [15:0]  up_reg [3];
    logic signed [33:0]  cr_reg [3];
    logic [31:0]         offp_reg, offm_reg;
    logic [M_DATA_W-1:0] m_data_reg;
    logic [M_USER_W-1:0] m_user_reg;
    logic                m_last_reg;

    // Input unpacking.
    logic signed [31:0] in_x, in_y, in_z;
    logic               in_kind, in_invalid, s_accept;
    logic signed [32:0] d_in [3];
    logic signed [32:0] cs_in [3];

    assign in_x       = s_tdata[31:0];
    assign in_y       = s_tdata[63:32];
    assign in_z       = s_tdata[95:64];
    assign in_kind    = s_tuser[0];
    assign in_invalid = s_tuser[1];
    assign s_tready   = (state_reg == ST_IDLE);
    assign s_accept   = s_tvalid && s_tready;

    always_comb begin
        d_in[0]  = {in_x[31], in_x} - {prev_x_reg[31], prev_x_reg};
        d_in[1]  = {in_y[31], in_y} - {prev_y_reg[31], prev_y_reg};
        d_in[2]  = {in_z[31], in_z} - {prev_z_reg[31], prev_z_reg};
        cs_in[0] = {in_x[31], in_x} + {prev_x_reg[31], prev_x_reg};
        cs_in[1] = {in_y[31], in_y} + {prev_y_reg[31], prev_y_reg};
        cs_in[2] = {in_z[31], in_z} + {prev_z_reg[31], prev_z_reg};
    end

    logic d_zero, vertical;
    assign vertical = (d_reg[0] == 33'sd0) && (d_reg[1] == 33'sd0);
    assign d_zero   = vertical && (d_reg[2] == 33'sd0);

    // Source vector of the unit being normalized.
    logic signed [33:0] vsrc [3];
    logic [33:0]        vmag [3];
    logic               vzero;

    always_comb begin
        case (usel_reg)
            U_AXIS: begin
                vsrc[0] = {d_reg[0][32], d_reg[0]};
                vsrc[1] = {d_reg[1][32], d_reg[1]};
                vsrc[2] = {d_reg[2][32], d_reg[2]};
            end
            U_SIDE: begin
                vsrc[0] = -{d_reg[1][32], d_reg[1]};
                vsrc[1] = {d_reg[0][32], d_reg[0]};
                vsrc[2] = 34'sd0;
            end
            default: begin
                vsrc[0] = cr_reg[0];
                vsrc[1] = cr_reg[1];
                vsrc[2] = cr_reg[2];
            end
        endcase
        for (int i = 0; i < 3; i++) begin
            vmag[i] = mag34(vsrc[i]);
        end
        vzero = (vmag[0] == 34'd0) && (vmag[1] == 34'd0) && (vmag[2] == 34'd0);
    end

    // Largest normalized magnitude.
    logic [33:0] a_max01, amax, a_cur, abs_d;
    logic        a_in_range;

    assign a_max01    = (a_reg[0] > a_reg[1]) ? a_reg[0] : a_reg[1];
    assign amax       = (a_max01 > a_reg[2]) ? a_max01 : a_reg[2];
    assign a_in_range = (amax[33:31] == 3'd0) && amax[30];
    assign a_cur      = a_reg[comp_reg];
    assign abs_d      = mag34({d_reg[comp_reg][32], d_reg[comp_reg]});

    // Normal of the current plane pair.
    logic signed [15:0] nk [3];
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            case (k_reg)
                2'd0:    nk[i] = ax_reg[i];
                2'd1:    nk[i] = sd_reg[i];
                default: nk[i] = up_reg[i];
            endcase
        end
    end

    // Shared multiplier and accumulator.
    logic signed [33:0] mul_a, mul_b;
    logic signed [67:0] prod, acc_base, sum_next;

    always_comb begin
        mul_a = 34'sd0;
        mul_b = 34'sd0;
        case (state_reg)
            ST_HSQ: begin
                mul_a = abs_d;
                mul_b = abs_d;
            end
            ST_USQ: begin
                mul_a = a_cur;
                mul_b = a_cur;
            end
            ST_CROSS: begin
                case (cnt_reg[2:0])
                    3'd0: begin
                        mul_a = {{18{ax_reg[1][15]}}, ax_reg[1]};
                        mul_b = {{18{sd_reg[2][15]}}, sd_reg[2]};
                    end
                    3'd1: begin
                        mul_a = {{18{ax_reg[2][15]}}, ax_reg[2]};
                        mul_b = {{18{sd_reg[1][15]}}, sd_reg[1]};
                    end
                    3'd2: begin
                        mul_a = {{18{ax_reg[2][15]}}, ax_reg[2]};
                        mul_b = {{18{sd_reg[0][15]}}, sd_reg[0]};
                    end
                    3'd3: begin
                        mul_a = {{18{ax_reg[0][15]}}, ax_reg[0]};
                        mul_b = {{18{sd_reg[2][15]}}, sd_reg[2]};
                    end
                    3'd4: begin
                        mul_a = {{18{ax_reg[0][15]}}, ax_reg[0]};
                        mul_b = {{18{sd_reg[1][15]}}, sd_reg[1]};
                    end
                    default: begin
                        mul_a = {{18{ax_reg[1][15]}}, ax_reg[1]};
                        mul_b = {{18{sd_reg[0][15]}}, sd_reg[0]};
                    end
                endcase
            end
            ST_DOT: begin
                mul_a = {{18{nk[comp_reg][15]}}, nk[comp_reg]};
                mul_b = {cs_reg[comp_reg][32], cs_reg[comp_reg]};
            end
            default: begin
                mul_a = 34'sd0;
                mul_b = 34'sd0;
            end
        endcase
    end

    assign prod     = mul_a * mul_b;
    assign acc_base = (comp_reg == 2'd0) ? 68'sd0 : acc_reg;
    assign sum_next = acc_base + prod;

    // Bit-serial square root step: two radicand bits per cycle.
    logic [35:0] rem_shift, trial;
    logic        root_ge;
    logic [31:0] root_next;

    assign rem_shift = {rem_reg[33:0], rad_reg[63:62]};
    assign trial     = {2'b00, root_reg, 2'b01};
    assign root_ge   = (rem_shift >= trial);
    assign root_next = {root_reg[30:0], root_ge};

    // Restoring divider step: one quotient bit per cycle.
    logic               div_ge;
    logic [15:0]        q_next;
    logic signed [15:0] q_signed;

    assign div_ge   = (drem_reg >= dsh_reg);
    assign q_next   = {q_reg[14:0], div_ge};
    assign q_signed = vneg_reg[comp_reg] ? 16'(-q_next) : q_next;

    // Plane offsets for the current normal.
    logic [32:0]        c_val;
    logic signed [67:0] dot_rnd;
    logic signed [53:0] dr54, c54, offp_w, offm_w;

    assign c_val   = {2'b00, margin_reg} + ((k_reg == 2'd0) ? {1'b0, half_reg} : 33'd0);
    assign dot_rnd = acc_reg + 68'sd16384;
    assign dr54    = {dot_rnd[67], dot_rnd[67:15]};
    assign c54     = {21'd0, c_val};
    assign offp_w  = -c54 - dr54;
    assign offm_w  = -c54 + dr54;

    logic out_free;
    assign out_free = !m_valid_reg || m_tready;

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= 5'd0;
            comp_reg      <= 2'd0;
            k_reg         <= 2'd0;
            usel_reg      <= U_AXIS;
            root_half_reg <= 1'b0;
            have_prev_reg <= 1'b0;
            prev_x_reg    <= 32'sd0;
            prev_y_reg    <= 32'sd0;
            prev_z_reg    <= 32'sd0;
            margin_reg    <= MARGIN_RESET;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                margin_reg <= cfg_wr_data;
            end
            if ((state_reg == ST_EMP || state_reg == ST_EMM) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (s_accept && !in_invalid) begin
                        prev_x_reg    <= in_x;
                        prev_y_reg    <= in_y;
                        prev_z_reg    <= in_z;
                        have_prev_reg <= 1'b1;
                        if (in_kind == KIND_WAYPOINT && have_prev_reg) begin
                            state_reg <= ST_CHK;
                        end
                    end
                end
                ST_CHK: begin
                    // A zero-length segment yields no planes.
                    if (d_zero) begin
                        state_reg <= ST_IDLE;
                    end else begin
                        comp_reg  <= 2'd0;
                        state_reg <= ST_HSQ;
                    end
                end
                ST_HSQ: begin
                    if (comp_reg == 2'd2) begin
                        comp_reg      <= 2'd0;
                        cnt_reg       <= 5'd0;
                        root_half_reg <= 1'b1;
                        state_reg     <= ST_ROOT;
                    end else begin
                        comp_reg <= comp_reg + 2'd1;
                    end
                end
                ST_ROOT: begin
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd31) begin
                        if (root_half_reg) begin
                            usel_reg  <= U_AXIS;
                            state_reg <= ST_USET;
                        end else begin
                            comp_reg  <= 2'd0;
                            state_reg <= ST_DINIT;
                        end
                    end
                end
                ST_USET: begin
                    state_reg <= vzero ? ST_UDONE : ST_UNORM;
                end
                ST_UNORM: begin
                    if (a_in_range) begin
                        comp_reg  <= 2'd0;
                        state_reg <= ST_USQ;
                    end
                end
                ST_USQ: begin
                    if (comp_reg == 2'd2) begin
                        cnt_reg       <= 5'd0;
                        root_half_reg <= 1'b0;
                        state_reg     <= ST_ROOT;
                    end else begin
                        comp_reg <= comp_reg + 2'd1;
                    end
                end
                ST_DINIT: begin
                    cnt_reg   <= 5'd0;
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd15) begin
                        if (comp_reg == 2'd2) begin
                            state_reg <= ST_UDONE;
                        end else begin
                            comp_reg  <= comp_reg + 2'd1;
                            state_reg <= ST_DINIT;
                        end
                    end
                end
                ST_UDONE: begin
                    case (usel_reg)
                        U_AXIS: begin
                            // A vertical segment takes a fixed side axis.
                            if (vertical) begin
                                cnt_reg   <= 5'd0;
                                state_reg <= ST_CROSS;
                            end else begin
                                usel_reg  <= U_SIDE;
                                state_reg <= ST_USET;
                            end
                        end
                        U_SIDE: begin
                            cnt_reg   <= 5'd0;
                            state_reg <= ST_CROSS;
                        end
                        default: begin
                            k_reg     <= 2'd0;
                            comp_reg  <= 2'd0;
                            state_reg <= ST_DOT;
                        end
                    endcase
                end
                ST_CROSS: begin
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd5) begin
                        usel_reg  <= U_UP;
                        state_reg <= ST_USET;
                    end
                end
                ST_DOT: begin
                    if (comp_reg == 2'd2) begin
                        state_reg <= ST_OFS;
                    end else begin
                        comp_reg <= comp_reg + 2'd1;
                    end
                end
                ST_OFS: begin
                    state_reg <= ST_EMP;
                end
                ST_EMP: begin
                    if (out_free) begin
                        state_reg <= ST_EMM;
                    end
                end
                ST_EMM: begin
                    if (out_free) begin
                        if (k_reg == 2'd2) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            k_reg     <= k_reg + 2'd1;
                            comp_reg  <= 2'd0;
                            state_reg <= ST_DOT;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    for (int i = 0; i < 3; i++) begin
                        d_reg[i]  <= d_in[i];
                        cs_reg[i] <= cs_in[i];
                    end
                end
            end
            ST_HSQ: begin
                acc_reg <= sum_next;
                if (comp_reg == 2'd2) begin
                    // Half length is the root of a quarter of the squared length.
                    rad_reg  <= sum_next[65:2];
                    root_reg <= 32'd0;
                    rem_reg  <= 36'd0;
                end
            end
            ST_ROOT: begin
                rem_reg  <= root_ge ? (rem_shift - trial) : rem_shift;
                root_reg <= root_next;
                rad_reg  <= {rad_reg[61:0], 2'b00};
                if (cnt_reg == 5'd31 && root_half_reg) begin
                    half_reg <= root_next;
                end
            end
            ST_USET: begin
                for (int i = 0; i < 3; i++) begin
                    a_reg[i]    <= vmag[i];
                    vneg_reg[i] <= vsrc[i][33];
                    if (vzero) begin
                        case (usel_reg)
                            U_AXIS:  ax_reg[i] <= 16'sd0;
                            U_SIDE:  sd_reg[i] <= 16'sd0;
                            default: up_reg[i] <= 16'sd0;
                        endcase
                    end
                end
            end
            ST_UNORM: begin
                for (int i = 0; i < 3; i++) begin
                    if (amax[33:31] != 3'd0) begin
                        a_reg[i] <= {1'b0, a_reg[i][33:1]};
                    end else if (!amax[30]) begin
                        a_reg[i] <= {a_reg[i][32:0], 1'b0};
                    end
                end
            end
            ST_USQ: begin
                acc_reg <= sum_next;
                if (comp_reg == 2'd2) begin
                    rad_reg  <= sum_next[63:0];
                    root_reg <= 32'd0;
                    rem_reg  <= 36'd0;
                end
            end
            ST_DINIT: begin
                // Rounded quotient: (a * 2^15 + len) / (2 * len).
                drem_reg <= {2'b00, a_cur[30:0], 15'd0} + {16'd0, root_reg};
                dsh_reg  <= {root_reg, 16'd0};
                q_reg    <= 16'd0;
            end
            ST_DIV: begin
                if (div_ge) begin
                    drem_reg <= drem_reg - dsh_reg;
                end
                dsh_reg <= {1'b0, dsh_reg[47:1]};
                q_reg   <= q_next;
                if (cnt_reg == 5'd15) begin
                    case (usel_reg)
                        U_AXIS:  ax_reg[comp_reg] <= q_signed;
                        U_SIDE:  sd_reg[comp_reg] <= q_signed;
                        default: up_reg[comp_reg] <= q_signed;
                    endcase
                end
            end
            ST_UDONE: begin
                if (usel_reg == U_AXIS && vertical) begin
                    sd_reg[0] <= 16'sd0;
                    sd_reg[1] <= Q14_ONE;
                    sd_reg[2] <= 16'sd0;
                end
            end
            ST_CROSS: begin
                // Even steps load the first product, odd steps subtract the second.
                if (!cnt_reg[0]) begin
                    acc_reg <= prod;
                end else begin
                    cr_reg[cnt_reg[2:1]] <= 34'(acc_reg - prod);
                end
            end
            ST_DOT: begin
                acc_reg <= sum_next;
            end
            ST_OFS: begin
                offp_reg <= sat54(offp_w);
                offm_reg <= sat54(offm_w);
            end
            ST_EMP: begin
                if (out_free) begin
                    m_data_reg <= {offp_reg, nk[2], nk[1], nk[0]};
                    m_user_reg <= {k_reg, 1'b0};
                    m_last_reg <= 1'b0;
                end
            end
            ST_EMM: begin
                if (out_free) begin
                    m_data_reg <= {offm_reg, 16'(-nk[2]), 16'(-nk[1]), 16'(-nk[0])};
                    m_user_reg <= {k_reg, 1'b1};
                    m_last_reg <= (k_reg == 2'd2);
                end
            end
            default: begin
            end
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

endmodule

### rtl/sbh_checker.sv
`timescale 1ns / 1ps

module sbh_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_tready,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [sbh_pkg::M_DATA_W-1:0] m_tdata,
    input logic [sbh_pkg::M_USER_W-1:0] m_tuser,
    input logic                         m_tlast
);
    import sbh_pkg::*;

    // The sixth plane, and only it, closes a box.
    a_last_on_sixth: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (m_tuser == PLANE_UP_NEG)))
        else $error("tlast does not match the sixth plane");

    a_plane_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser <= PLANE_UP_NEG))
        else $error("plane index out of range");

    // While a box is only partly delivered the block takes no new point.
    a_busy_mid_box: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tlast) |-> !s_tready)
        else $error("point accepted in the middle of a box");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result beat changed");

endmodule

bind segment_box_halfspaces sbh_checker u_sbh_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
